>>> hdl/assert_macros.svh
// Assertion macros used by the top level of the vector sum and mean accumulator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off while arst_n is low.
`define VSMA_CHECK(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off while arst_n is low.
`define VSMA_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/vsma_pkg.sv
// Types and constants shared by the vector sum and mean accumulator.
package vsma_pkg;

	// Fixed field widths.
	localparam int ELEM_W = 32;
	localparam int SUM_W  = 64;
	localparam int CNT_W  = 32;
	localparam int POS_W  = 7;
	localparam int IDX_W  = 6;
	localparam int STAT_W = 2;

	// Command codes of an input beat.
	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ACCUM = 2'd1,
		CMD_AVG   = 2'd2,
		CMD_SUM   = 2'd3
	} cmd_t;

	// Status codes of a result beat.
	localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_EMPTY   = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_DIM_ERR = 2'd2;

	// Saturation limits of a sum.
	localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef struct packed {
		cmd_t                     cmd;
		logic signed [ELEM_W-1:0] element_value;
		logic                     element_last;
	} in_item_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] result_value;
		logic [IDX_W-1:0]        dim_index;
		logic                    result_last;
		logic [STAT_W-1:0]       status;
	} out_item_t;

	// Update token that travels down the row of cells.
	typedef struct packed {
		logic                     valid;
		logic                     write;
		logic [IDX_W-1:0]         pos;
		logic signed [ELEM_W-1:0] value;
	} tok_t;

	// Readout control broadcast to every cell.
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage

>>> hdl/vsma_stream_if.sv
// Valid/ready stream interface carrying one payload per beat.
interface vsma_stream_if #(parameter type payload_t = logic) ();

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

>>> hdl/vector_sum_mean_accumulator.sv
// Top level of the vector sum and mean accumulator.
// Elements are taken one per cycle with cmd accumulate; each becomes an update token that
// walks a row of MAX_DIM cells, one cell per cycle, and lands in the cell of its dimension.
// Clear is also taken every cycle. An emit command waits until the last token has left the
// row, snapshots all sums together and shifts them out of cell zero: emit sums gives one
// result per cycle while the output is not stalled; emit averages fetches each sum, divides
// it in the bit-serial divider, which retires one quotient bit per cycle over 64 steps, and
// places the quotient before the next sum is fetched. Error and empty reports are one
// result. No input is taken during an emission run. The sums have no reset; reads come
// only from entries the first vector wrote.
`include "assert_macros.svh"

module vector_sum_mean_accumulator #(
	parameter int MAX_DIM = 64
) (
	input logic                clk,
	input logic                arst_n,
	vsma_stream_if.sink        items,
	vsma_stream_if.source      results
);

	localparam int DRAIN_W = $clog2(MAX_DIM + 1);
	localparam logic [vsma_pkg::POS_W-1:0] DIM_LIM = vsma_pkg::POS_W'(MAX_DIM);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_DRAIN = 6'b000010,
		S_FLAG  = 6'b000100,
		S_FETCH = 6'b001000,
		S_DIV   = 6'b010000,
		S_PUT   = 6'b100000
	} state_t;

	state_t                             state_q, state_d;
	logic [vsma_pkg::CNT_W-1:0]         count_q;
	logic [vsma_pkg::POS_W-1:0]         gdim_q;
	logic [vsma_pkg::POS_W-1:0]         pos_q;
	logic [vsma_pkg::POS_W-1:0]         pos_nxt;
	logic                               err_q;
	logic                               avg_q;
	logic [DRAIN_W-1:0]                 drain_q;
	logic [vsma_pkg::IDX_W-1:0]         idx_q;
	logic                               idx_inc;
	logic                               last_idx;
	vsma_pkg::tok_t                     tok_q;
	vsma_pkg::tok_t                     tok_d;
	logic                               out_v_q;
	vsma_pkg::out_item_t                out_q, out_d;
	logic                               out_load;
	logic                               out_free;
	logic                               acc;
	vsma_pkg::cell_ctl_t                ctl;
	logic                               div_start;
	logic                               div_done;
	logic signed [vsma_pkg::SUM_W-1:0]  quotient;
	vsma_pkg::tok_t                     tok_w [MAX_DIM+1];
	logic signed [vsma_pkg::SUM_W-1:0]  rd_w [MAX_DIM+1];

	assign acc          = items.valid && items.ready;
	assign items.ready  = (state_q == S_IDLE);
	assign out_free     = !out_v_q || results.ready;
	assign pos_nxt      = pos_q + 1'b1;
	assign last_idx     = ({1'b0, idx_q} + 1'b1) == gdim_q;

	// Update token for an accepted element: the first vector writes, later vectors add.
	always_comb begin
		tok_d       = '0;
		tok_d.write = (count_q == '0);
		tok_d.pos   = pos_q[vsma_pkg::IDX_W-1:0];
		tok_d.value = items.data.element_value;
		if (acc && items.data.cmd == vsma_pkg::CMD_ACCUM && !err_q) begin
			if (count_q == '0) begin
				tok_d.valid = (pos_q < DIM_LIM);
			end else begin
				tok_d.valid = (pos_q < gdim_q);
			end
		end
	end

	// Group bookkeeping and token issue, all decided when a beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			gdim_q  <= '0;
			pos_q   <= '0;
			err_q   <= 1'b0;
			avg_q   <= 1'b0;
			drain_q <= '0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_d;
			if (acc && items.data.cmd == vsma_pkg::CMD_ACCUM) begin
				drain_q <= DRAIN_W'(MAX_DIM);
			end else if (drain_q != '0) begin
				drain_q <= drain_q - 1'b1;
			end
			if (acc) begin
				unique case (items.data.cmd)
					vsma_pkg::CMD_CLEAR: begin
						count_q <= '0;
						gdim_q  <= '0;
						pos_q   <= '0;
						err_q   <= 1'b0;
					end
					vsma_pkg::CMD_ACCUM: begin
						if (!err_q) begin
							if (count_q == '0) begin
								// First vector fixes the dimension.
								if (pos_q >= DIM_LIM) begin
									err_q <= 1'b1;
								end else begin
									if (items.data.element_last) begin
										gdim_q  <= pos_nxt;
										count_q <= vsma_pkg::CNT_W'(1);
										pos_q   <= '0;
									end else begin
										pos_q <= pos_nxt;
									end
								end
							end else if (pos_q >= gdim_q) begin
								err_q <= 1'b1;
							end else begin
								// Later vector: the sum is updated before the length check.
								if (items.data.element_last) begin
									if (pos_nxt != gdim_q) begin
										err_q <= 1'b1;
									end else begin
										if (count_q != '1) begin
											count_q <= count_q + 1'b1;
										end
										pos_q <= '0;
									end
								end else begin
									pos_q <= pos_nxt;
								end
							end
						end
					end
					vsma_pkg::CMD_AVG: avg_q <= 1'b1;
					vsma_pkg::CMD_SUM: avg_q <= 1'b0;
				endcase
			end
		end
	end

	// Emission sequencer.
	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		div_start = 1'b0;
		out_load  = 1'b0;
		idx_inc   = 1'b0;
		out_d     = '{result_value: rd_w[0], dim_index: idx_q, result_last: last_idx,
			status: vsma_pkg::STATUS_OK};
		unique case (state_q)
			S_IDLE: begin
				if (acc && (items.data.cmd == vsma_pkg::CMD_AVG ||
					items.data.cmd == vsma_pkg::CMD_SUM)) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (drain_q == '0) begin
					if (err_q || count_q == '0 || gdim_q == '0) begin
						state_d = S_FLAG;
					end else begin
						ctl.load = 1'b1;
						state_d  = S_FETCH;
					end
				end
			end
			S_FLAG: begin
				out_d = '{result_value: '0, dim_index: '0, result_last: 1'b1,
					status: err_q ? vsma_pkg::STATUS_DIM_ERR : vsma_pkg::STATUS_EMPTY};
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_FETCH: begin
				if (avg_q) begin
					div_start = 1'b1;
					ctl.shift = 1'b1;
					state_d   = S_DIV;
				end else if (out_free) begin
					out_load  = 1'b1;
					ctl.shift = 1'b1;
					if (last_idx) begin
						state_d = S_IDLE;
					end else begin
						idx_inc = 1'b1;
					end
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_PUT;
				end
			end
			S_PUT: begin
				out_d.result_value = quotient;
				if (out_free) begin
					out_load = 1'b1;
					if (last_idx) begin
						state_d = S_IDLE;
					end else begin
						idx_inc = 1'b1;
						state_d = S_FETCH;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (results.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign results.valid = out_v_q;
	assign results.data  = out_q;

	// Row of sum cells.
	assign tok_w[0]       = tok_q;
	assign rd_w[MAX_DIM]  = '0;

	for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
		vsma_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (vsma_pkg::IDX_W'(g)),
			.tok_in   (tok_w[g]),
			.tok_out  (tok_w[g+1]),
			.ctl      (ctl),
			.rd_in    (rd_w[g+1]),
			.rd_out   (rd_w[g])
		);
	end

	vsma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rd_w[0]),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// A snapshot is taken only after every update token has left the row.
	`VSMA_CHECK(a_snap_after_drain, ctl.load, drain_q == '0, "snapshot with updates in flight")
	// A group with counted vectors always has a dimension within range.
	`VSMA_CHECK(a_count_has_dim, count_q != '0,
		gdim_q != '0 && gdim_q <= DIM_LIM, "bad group dimension")
	// Error and empty reports are single results at dimension zero.
	`VSMA_CHECK(a_flag_single, out_v_q && out_q.status != vsma_pkg::STATUS_OK,
		out_q.result_last && out_q.dim_index == '0, "flag result not single")
	// A token leaving the row was meant for a cell that exists.
	`VSMA_CHECK(a_tok_in_range, tok_w[MAX_DIM].valid,
		vsma_pkg::POS_W'(tok_w[MAX_DIM].pos) < DIM_LIM, "token position out of range")
	// A finished division is always followed by placing its result.
	`VSMA_NEXT(a_div_to_put, div_done, state_q == S_PUT, "division result not placed")

endmodule

>>> hdl/vsma_cell.sv
// One cell of the row: holds the running sum of one dimension.
module vsma_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [vsma_pkg::IDX_W-1:0]       cell_idx,
	input  vsma_pkg::tok_t                   tok_in,
	output vsma_pkg::tok_t                   tok_out,
	input  vsma_pkg::cell_ctl_t              ctl,
	input  logic signed [vsma_pkg::SUM_W-1:0] rd_in,
	output logic signed [vsma_pkg::SUM_W-1:0] rd_out
);

	logic signed [vsma_pkg::SUM_W-1:0] sum_q;
	logic signed [vsma_pkg::SUM_W-1:0] rd_q;
	vsma_pkg::tok_t                    tok_s1;
	logic                              hit;
	logic [vsma_pkg::SUM_W-1:0]        elem_ext;
	logic [vsma_pkg::SUM_W:0]          add_full;
	logic [vsma_pkg::SUM_W-1:0]        add_sat;

	// The token belongs to this cell when its position matches.
	assign hit = tok_in.valid && (tok_in.pos == cell_idx);

	// Sign-extend the element and add it with saturation at the 64-bit limits.
	assign elem_ext = {{(vsma_pkg::SUM_W-vsma_pkg::ELEM_W){tok_in.value[vsma_pkg::ELEM_W-1]}},
		tok_in.value};
	assign add_full = {sum_q[vsma_pkg::SUM_W-1], sum_q} + {elem_ext[vsma_pkg::SUM_W-1], elem_ext};

	always_comb begin
		if (add_full[vsma_pkg::SUM_W] != add_full[vsma_pkg::SUM_W-1]) begin
			add_sat = add_full[vsma_pkg::SUM_W] ? vsma_pkg::SUM_MIN : vsma_pkg::SUM_MAX;
		end else begin
			add_sat = add_full[vsma_pkg::SUM_W-1:0];
		end
	end

	// The first vector of a group writes the sum, later vectors add into it.
	always_ff @(posedge clk) begin
		if (hit) begin
			sum_q <= tok_in.write ? signed'(elem_ext) : signed'(add_sat);
		end
	end

	// Pass the token on to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else begin
			tok_s1 <= tok_in;
		end
	end

	// Readout register: snapshot of the sum, then shifts toward cell zero.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rd_q <= sum_q;
		end else if (ctl.shift) begin
			rd_q <= rd_in;
		end
	end

	assign tok_out = tok_s1;
	assign rd_out  = rd_q;

endmodule

>>> hdl/vsma_div.sv
// Bit-serial signed divider: 64-bit sum over a 32-bit unsigned count, truncating.
module vsma_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [vsma_pkg::SUM_W-1:0] dividend,
	input  logic [vsma_pkg::CNT_W-1:0]        divisor,
	output logic                              done,
	output logic signed [vsma_pkg::SUM_W-1:0] quotient
);

	localparam int STEP_W = $clog2(vsma_pkg::SUM_W);

	logic                       busy_q;
	logic                       done_q;
	logic [STEP_W-1:0]          step_q;
	logic                       neg_q;
	logic [vsma_pkg::SUM_W-1:0] dvd_q;
	logic [vsma_pkg::CNT_W-1:0] rem_q;
	logic [vsma_pkg::CNT_W-1:0] div_q;
	logic [vsma_pkg::SUM_W-1:0] mag;
	logic [vsma_pkg::CNT_W:0]   trial;
	logic [vsma_pkg::CNT_W:0]   diff;
	logic                       ge;

	// Work on magnitudes; the sign is applied to the quotient at the end.
	assign mag   = dividend[vsma_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
	assign trial = {rem_q, dvd_q[vsma_pkg::SUM_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};

	// Step counter and handshake flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One restoring step per cycle; quotient bits shift in behind the dividend.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[vsma_pkg::SUM_W-1];
			dvd_q <= mag;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[vsma_pkg::CNT_W-1:0] : trial[vsma_pkg::CNT_W-1:0];
			dvd_q <= {dvd_q[vsma_pkg::SUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? signed'(~dvd_q + 1'b1) : signed'(dvd_q);

endmodule
